FILE: rtl/core/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int CHAN_W  = 8;
  localparam int ALPHA_W = 8;
  localparam int QUO_W   = 16;
  localparam int HUE_W   = QUO_W;
  localparam int SAT_W   = QUO_W;
  // 6*range needs three more bits than a channel
  localparam int TURN_W  = CHAN_W + 3;
  localparam int SATN_W  = CHAN_W + SAT_W;

  localparam int IN_DATA_W  = ((3 * CHAN_W + ALPHA_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((HUE_W + SAT_W + CHAN_W + ALPHA_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
  } pixel_t;

  typedef struct packed {
    logic [ALPHA_W-1:0]     alpha;
    logic [CHAN_W-1:0]      hi;
    logic [CHAN_W-1:0]      range;
    sector_t                sector;
    logic signed [CHAN_W:0] diff;
  } minmax_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [CHAN_W-1:0]  hi;
    logic               gray;
    logic [TURN_W-1:0]  turn;
    logic [TURN_W-1:0]  num;
    logic [SATN_W-1:0]  sat_num;
  } divin_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [CHAN_W-1:0]  hi;
    logic               gray;
  } side_t;

  typedef struct packed {
    logic [ALPHA_W-1:0] alpha;
    logic [CHAN_W-1:0]  brightness;
    logic [SAT_W-1:0]   saturation;
    logic [HUE_W-1:0]   hue;
  } result_t;

endpackage

FILE: rtl/core/rgbhsv_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Requires rem0 < dvs so the quotient fits Q_W bits.
module rgbhsv_div #(
  parameter int DIV_W = 8,
  parameter int Q_W   = 16
) (
  input  logic             clk,
  input  logic [Q_W-1:0]   en,
  input  logic [DIV_W-1:0] dvs,
  input  logic [DIV_W-1:0] rem0,
  input  logic [Q_W-1:0]   low,
  output logic [Q_W-1:0]   quo
);

  logic [DIV_W-1:0] dvs_r [Q_W];
  logic [DIV_W-1:0] rem_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   quo_r [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_stg
    logic [DIV_W-1:0] dvs_in;
    logic [DIV_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             take;

    if (k == 0) begin : g_first
      assign dvs_in = dvs;
      assign rem_in = rem0;
      assign low_in = low;
      assign quo_in = '0;
    end else begin : g_next
      assign dvs_in = dvs_r[k-1];
      assign rem_in = rem_r[k-1];
      assign low_in = low_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign diff  = trial - {1'b0, dvs_in};
    assign take  = (trial >= {1'b0, dvs_in});

    always_ff @(posedge clk) begin
      if (en[k]) begin
        dvs_r[k] <= dvs_in;
        rem_r[k] <= take ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
        low_r[k] <= {low_in[Q_W-2:0], 1'b0};
        quo_r[k] <= {quo_in[Q_W-2:0], take};
      end
    end
  end

  assign quo = quo_r[Q_W-1];

endmodule

FILE: rtl/core/rgb_to_hsv_converter_core.sv
// RGB to HSV pixel converter, fully pipelined.
// Stages: input reg, min/max stage, setup stage, 16 divider stages, output reg.
// Throughput: one pixel per cycle while the output skid is empty;
// each divider retires one quotient bit per stage.
// Reset: synchronous active-low rst_n clears all valid bits and the output skid;
// payload registers are not reset.
module rgb_to_hsv_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [31:24] alpha_in
  input  logic [rgbhsv_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [15:0] hue_out, [31:16] saturation_out, [39:32] brightness_out,
  // [47:40] alpha_out
  output logic [rgbhsv_pkg::OUT_DATA_W-1:0] out_tdata
);

  import rgbhsv_pkg::*;

  // input reg, min/max, divider setup, then the divider stages
  localparam int NS = 3 + QUO_W;

  logic [NS-1:0] v_r;
  logic          en;

  pixel_t  pix_r;
  minmax_t mm_r, mm_nxt;
  divin_t  dv_r, dv_nxt;
  side_t   side_r [QUO_W];

  logic [SAT_W-1:0] sat_quo;
  logic [HUE_W-1:0] hue_quo;
  result_t          res;

  logic    out_v_r, out_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t out_r, out_nxt;
  result_t skid_r, skid_nxt;
  logic    pipe_out_v;

  // Whole pipe moves together; stalls only once the skid holds an item,
  // so a transaction is taken even while a result waits downstream.
  assign en        = !skid_v_r;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_tvalid};
    end
  end

  // stage 0: input register
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pixel_t'(in_tdata[3*CHAN_W+ALPHA_W-1:0]);
    end
  end

  // stage 1: largest/smallest channel, sector, signed difference.
  // Ties: red beats green, green beats blue.
  always_comb begin
    logic [CHAN_W-1:0] lo;
    mm_nxt       = '0;
    mm_nxt.alpha = pix_r.alpha;
    if (pix_r.red >= pix_r.green && pix_r.red >= pix_r.blue) begin
      mm_nxt.sector = SEC_RED;
      mm_nxt.hi     = pix_r.red;
      mm_nxt.diff   = $signed({1'b0, pix_r.green}) - $signed({1'b0, pix_r.blue});
    end else if (pix_r.green >= pix_r.blue) begin
      mm_nxt.sector = SEC_GREEN;
      mm_nxt.hi     = pix_r.green;
      mm_nxt.diff   = $signed({1'b0, pix_r.blue}) - $signed({1'b0, pix_r.red});
    end else begin
      mm_nxt.sector = SEC_BLUE;
      mm_nxt.hi     = pix_r.blue;
      mm_nxt.diff   = $signed({1'b0, pix_r.red}) - $signed({1'b0, pix_r.green});
    end
    lo = (pix_r.red < pix_r.green) ? pix_r.red : pix_r.green;
    lo = (lo < pix_r.blue) ? lo : pix_r.blue;
    mm_nxt.range = mm_nxt.hi - lo;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mm_r <= mm_nxt;
    end
  end

  // stage 2: hue numerator wrapped into [0, 6*range), turn, sat numerator
  always_comb begin
    logic [TURN_W-1:0]        rng;
    logic signed [TURN_W+1:0] base;
    logic signed [TURN_W+1:0] sum;
    rng  = TURN_W'(mm_r.range);
    base = '0;
    unique case (mm_r.sector)
      SEC_RED:   base = '0;
      SEC_GREEN: base = $signed({2'b00, rng << 1});
      SEC_BLUE:  base = $signed({2'b00, rng << 2});
      default:   base = '0;
    endcase
    dv_nxt       = '0;
    dv_nxt.alpha = mm_r.alpha;
    dv_nxt.hi    = mm_r.hi;
    dv_nxt.gray  = (mm_r.range == '0);
    dv_nxt.turn  = (rng << 2) + (rng << 1);
    sum = base + (TURN_W+2)'(mm_r.diff);
    if (sum < 0) begin
      sum = sum + $signed({2'b00, dv_nxt.turn});
    end
    dv_nxt.num     = sum[TURN_W-1:0];
    // range * (2^16 - 1)
    dv_nxt.sat_num = {mm_r.range, SAT_W'(0)} - SATN_W'(mm_r.range);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r <= dv_nxt;
    end
  end

  // divider stages; side data rides alongside
  rgbhsv_div #(
    .DIV_W (CHAN_W),
    .Q_W   (SAT_W)
  ) u_sat_div (
    .clk  (clk),
    .en   ({SAT_W{en}}),
    .dvs  (dv_r.hi),
    .rem0 (dv_r.sat_num[SATN_W-1:SAT_W]),
    .low  (dv_r.sat_num[SAT_W-1:0]),
    .quo  (sat_quo)
  );

  rgbhsv_div #(
    .DIV_W (TURN_W),
    .Q_W   (HUE_W)
  ) u_hue_div (
    .clk  (clk),
    .en   ({HUE_W{en}}),
    .dvs  (dv_r.turn),
    .rem0 (dv_r.num),
    .low  ('0),
    .quo  (hue_quo)
  );

  for (genvar k = 0; k < QUO_W; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en) begin
        if (k == 0) begin
          side_r[k] <= '{alpha: dv_r.alpha, hi: dv_r.hi, gray: dv_r.gray};
        end else begin
          side_r[k] <= side_r[(k == 0) ? 0 : k-1];
        end
      end
    end
  end

  // gray or black pixel: hue and saturation forced to zero
  always_comb begin
    res.alpha      = side_r[QUO_W-1].alpha;
    res.brightness = side_r[QUO_W-1].hi;
    res.saturation = side_r[QUO_W-1].gray ? '0 : sat_quo;
    res.hue        = side_r[QUO_W-1].gray ? '0 : hue_quo;
  end

  // output register plus one-entry skid
  assign pipe_out_v = v_r[NS-1] && en;

  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_nxt  = 1'b1;
        out_nxt    = skid_r;
        skid_v_nxt = 1'b0;
      end else begin
        out_v_nxt = pipe_out_v;
        out_nxt   = res;
      end
    end else if (pipe_out_v) begin
      skid_v_nxt = 1'b1;
      skid_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DATA_W'(out_r);

endmodule

FILE: rtl/core/rgbhsv_chk.sv
module rgbhsv_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tready,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [rgbhsv_pkg::OUT_DATA_W-1:0] out_tdata
);

  import rgbhsv_pkg::*;

  localparam int SAT_LO = HUE_W;
  localparam int BRT_LO = HUE_W + SAT_W;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  // nothing comes out right after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // with no result pending, the pipe must take input
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // black pixel gives zero hue and saturation
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[BRT_LO+CHAN_W-1:BRT_LO] == '0 |->
      out_tdata[BRT_LO-1:0] == '0)
    else $error("black pixel with nonzero hue or saturation");

  // zero saturation means gray, so hue must be zero
  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[BRT_LO-1:SAT_LO] == '0 |->
      out_tdata[HUE_W-1:0] == '0)
    else $error("gray pixel with nonzero hue");

endmodule

bind rgb_to_hsv_converter_core rgbhsv_chk u_rgbhsv_chk (.*);

FILE: tb/tb_rgb_to_hsv_converter_core.sv
module tb_rgb_to_hsv_converter_core;
  import rgbhsv_pkg::*;

  // Pixel sent, plus the HSV result the converter must return for it.
  typedef struct {
    pixel_t  px;
    result_t hsv;
  } hsv_expect_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [31:24] alpha_in
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] hue_out, [31:16] saturation_out, [39:32] brightness_out,
  // [47:40] alpha_out
  logic [OUT_DATA_W-1:0] out_tdata;

  hsv_expect_t expected_hsv[$];
  int          mismatch_count = 0;
  bit          idle_enable    = 1'b1;  // random gaps on the input side
  bit          stall_enable   = 1'b1;  // random back-pressure on the output side
  int          stall_left     = 0;

  rgb_to_hsv_converter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Exact integer HSV conversion.
  // Largest channel picks the sector; ties go red, then green, then blue.
  // Black and grey pixels give hue 0 and saturation 0.
  function automatic result_t predict_hsv(pixel_t px);
    int unsigned r, g, b, hi, lo, span, turn;
    longint      num;
    sector_t     sec;
    result_t     res;
    r    = px.red;
    g    = px.green;
    b    = px.blue;
    hi   = (r > g) ? r : g;
    hi   = (hi > b) ? hi : b;
    lo   = (r < g) ? r : g;
    lo   = (lo < b) ? lo : b;
    span = hi - lo;
    res.alpha      = px.alpha;
    res.brightness = hi[CHAN_W-1:0];
    res.saturation = '0;
    res.hue        = '0;
    if (hi != 0) begin
      res.saturation = SAT_W'((span * 32'd65535) / hi);
      if (span != 0) begin
        turn = 6 * span;
        if (r == hi)      sec = SEC_RED;
        else if (g == hi) sec = SEC_GREEN;
        else              sec = SEC_BLUE;
        case (sec)
          SEC_RED:   num = longint'(g) - longint'(b);
          SEC_GREEN: num = 2 * longint'(span) + longint'(b) - longint'(r);
          default:   num = 4 * longint'(span) + longint'(r) - longint'(g);
        endcase
        // negative hue wraps by one full turn
        if (num < 0) num = num + turn;
        res.hue = HUE_W'((num << HUE_W) / turn);
      end
    end
    return res;
  endfunction

  // Drive one pixel and hold it until the converter takes it. Called right
  // after a rising edge; without an idle burst it returns on the accepting edge
  // with in_tvalid still high, so back-to-back calls stream with no bubble.
  task automatic send_pixel(input pixel_t px);
    hsv_expect_t e;
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    e.px  = px;
    e.hsv = predict_hsv(px);
    expected_hsv.push_back(e);
    // random idle burst after this transaction
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic pixel_t make_pixel(int r, int g, int b, int a);
    pixel_t px;
    px.red   = r[CHAN_W-1:0];
    px.green = g[CHAN_W-1:0];
    px.blue  = b[CHAN_W-1:0];
    px.alpha = a[ALPHA_W-1:0];
    return px;
  endfunction

  // Random pixel biased toward the interesting corners: greys, two equal channels,
  // small values, ranges of at most one and a channel at full scale.
  function automatic pixel_t random_pixel();
    pixel_t px;
    int     base;
    px = pixel_t'($urandom);
    base = $urandom_range(0, 255);
    case ($urandom_range(0, 9))
      0: begin  // grey, includes black and white
        px.red = CHAN_W'(base); px.green = CHAN_W'(base); px.blue = CHAN_W'(base);
      end
      1: begin  // two channels made equal
        case ($urandom_range(0, 2))
          0:       px.green = px.red;
          1:       px.blue  = px.green;
          default: px.blue  = px.red;
        endcase
      end
      2: begin  // small values
        px.red   = CHAN_W'($urandom_range(0, 3));
        px.green = CHAN_W'($urandom_range(0, 3));
        px.blue  = CHAN_W'($urandom_range(0, 3));
      end
      3: begin  // range of at most one
        px.red   = CHAN_W'(base);
        px.green = CHAN_W'((base == 255) ? 254 : base + $urandom_range(0, 1));
        px.blue  = CHAN_W'((base == 255) ? 255 : base + $urandom_range(0, 1));
      end
      4: begin  // one channel at full scale
        case ($urandom_range(0, 2))
          0:       px.red   = 8'hFF;
          1:       px.green = 8'hFF;
          default: px.blue  = 8'hFF;
        endcase
      end
      default: ;  // fully random
    endcase
    return px;
  endfunction

  // Result checker and output back-pressure.
  always @(posedge clk) begin : hsv_check
    result_t     got;
    hsv_expect_t e;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata);
      if (expected_hsv.size() == 0) begin
        $display("%0t unexpected result transaction: expected none actual %h",
                 $time, out_tdata);
        mismatch_count++;
      end else begin
        e = expected_hsv.pop_front();
        if (got.hue !== e.hsv.hue) begin
          $display("%0t hue mismatch (rgba %h): expected %0d actual %0d",
                   $time, e.px, e.hsv.hue, got.hue);
          mismatch_count++;
        end
        if (got.saturation !== e.hsv.saturation) begin
          $display("%0t saturation mismatch (rgba %h): expected %0d actual %0d",
                   $time, e.px, e.hsv.saturation, got.saturation);
          mismatch_count++;
        end
        if (got.brightness !== e.hsv.brightness) begin
          $display("%0t brightness mismatch (rgba %h): expected %0d actual %0d",
                   $time, e.px, e.hsv.brightness, got.brightness);
          mismatch_count++;
        end
        if (got.alpha !== e.hsv.alpha) begin
          $display("%0t alpha mismatch (rgba %h): expected %0d actual %0d",
                   $time, e.px, e.hsv.alpha, got.alpha);
          mismatch_count++;
        end
      end
    end
    // random stall bursts
    if (!stall_enable) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 6) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Channel extremes, primaries, near-secondaries and alpha limits.
  task automatic test_extremes();
    send_pixel(make_pixel(0, 0, 0, 0));          // black
    send_pixel(make_pixel(255, 255, 255, 255));  // white
    send_pixel(make_pixel(128, 128, 128, 85));   // mid grey
    send_pixel(make_pixel(255, 0, 0, 255));      // pure red
    send_pixel(make_pixel(0, 255, 0, 0));        // pure green
    send_pixel(make_pixel(0, 0, 255, 170));      // pure blue
    send_pixel(make_pixel(1, 0, 0, 1));          // smallest nonzero red
    send_pixel(make_pixel(0, 1, 0, 2));
    send_pixel(make_pixel(0, 0, 1, 4));
    send_pixel(make_pixel(255, 0, 1, 8));        // red largest, hue wraps
    send_pixel(make_pixel(255, 254, 0, 16));     // just below yellow
    send_pixel(make_pixel(1, 255, 0, 32));       // green sector, negative diff
    send_pixel(make_pixel(255, 1, 255, 64));     // near-magenta
    send_pixel(make_pixel(254, 255, 255, 128));  // range one at the top
    send_pixel(make_pixel(170, 85, 0, 127));
  endtask

  // Ties for the largest channel: red over green, green over blue, red over blue.
  task automatic test_tie_breaks();
    send_pixel(make_pixel(255, 255, 0, 10));     // yellow
    send_pixel(make_pixel(0, 255, 255, 20));     // cyan
    send_pixel(make_pixel(255, 0, 255, 30));     // magenta
    send_pixel(make_pixel(200, 200, 17, 40));
    send_pixel(make_pixel(3, 90, 90, 50));
    send_pixel(make_pixel(77, 12, 77, 60));
  endtask

  // Random pixels with input gaps and output stalls.
  task automatic test_random_pixels(input int count);
    repeat (count) send_pixel(random_pixel());
  endtask

  // Full-rate streaming with no gaps or stalls.
  task automatic test_back_to_back(input int count);
    idle_enable  = 1'b0;
    stall_enable = 1'b0;
    repeat (count) send_pixel(random_pixel());
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_extremes();
    test_tie_breaks();
    test_random_pixels(1400);
    test_back_to_back(330);
    in_tvalid <= 1'b0;

    // drain, then give the pipeline time to show any extra transaction
    while (expected_hsv.size() != 0) @(posedge clk);
    repeat (25) @(posedge clk);

    if (mismatch_count == 0 && expected_hsv.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/rgbhsv_pkg.sv
rtl/core/rgbhsv_div.sv
rtl/core/rgb_to_hsv_converter_core.sv
rtl/core/rgbhsv_chk.sv
tb/tb_rgb_to_hsv_converter_core.sv
